// ===== rtl/bfpa_pkg.sv =====
// Shared types and constants for the best-fit partition allocator.
package bfpa_pkg;

  localparam int unsigned NUM_PARTITIONS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF      = 16;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  part_index;
    logic [15:0] part_size;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  chosen_partition;
    logic [15:0] leftover;
    logic [31:0] total_leftover;
  } rsp_t;

endpackage

// ===== rtl/bfpa_cell.sv =====
// One partition slot: size and used flag, plus one stage of the best-fit scan chain.
module bfpa_cell import bfpa_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_en_i,
  input  logic [3:0]           load_idx_i,
  input  logic [SIZE_BITS-1:0] load_size_i,
  input  logic                 mark_en_i,
  input  logic [IDX_W-1:0]     mark_idx_i,
  input  logic [SIZE_BITS-1:0] req_size_i,
  input  logic                 found_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [SIZE_BITS-1:0] left_i,
  output logic                 found_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [SIZE_BITS-1:0] left_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 used_q;
  logic                 found_q;
  logic [IDX_W-1:0]     idx_q;
  logic [SIZE_BITS-1:0] left_q;

  logic                 load_hit;
  logic                 mark_hit;
  logic                 cand;
  logic                 take;
  logic [SIZE_BITS-1:0] own_left;

  assign load_hit = load_en_i && (32'(load_idx_i) == 32'(CELL_IDX));
  assign mark_hit = mark_en_i && (mark_idx_i == IDX_W'(CELL_IDX));
  assign cand     = !used_q && (size_q != '0) && (size_q >= req_size_i);
  assign own_left = size_q - req_size_i;
  assign take     = cand && (!found_i || (own_left < left_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '0;
      used_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (load_hit) begin
        size_q <= load_size_i;
        used_q <= 1'b0;
      end else if (mark_hit) begin
        used_q <= 1'b1;
      end
      found_q <= found_i || cand;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= take ? IDX_W'(CELL_IDX) : idx_i;
    left_q <= take ? own_left : left_i;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign left_o  = left_q;

endmodule

// ===== rtl/best_fit_partition_allocator.sv =====
// Top level of the best-fit partition allocator: request control, scan chain, running total.
//
// A load request writes one slot and returns its result in the next cycle; busy stays low,
// so loads may follow back to back. An allocate request raises busy and sends a probe down
// the row of NUM_PARTITIONS slot cells, one cell per cycle, each keeping the tighter fit;
// once the probe has left the last cell the tail of the chain holds the winner, which is marked used
// and reported. Each result appears for exactly one cycle with done_o high and must be taken
// then; a new request may be accepted in that same cycle.
module best_fit_partition_allocator import bfpa_pkg::*; #(
  parameter int unsigned NUM_PARTITIONS = NUM_PARTITIONS_DEF,
  parameter int unsigned SIZE_BITS      = SIZE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int unsigned CNT_W = IDX_W;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SIZE_BITS-1:0] req_size_q, req_size_d;
  logic [31:0]          sum_q, sum_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 done_q, done_d;

  logic                 load_en;
  logic                 mark_en;
  logic [SIZE_BITS-1:0] load_size;
  logic [32:0]          sum_ext;

  logic                 chain_found [NUM_PARTITIONS+1];
  logic [IDX_W-1:0]     chain_idx   [NUM_PARTITIONS+1];
  logic [SIZE_BITS-1:0] chain_left  [NUM_PARTITIONS+1];

  assign chain_found[0] = 1'b0;
  assign chain_idx[0]   = '0;
  assign chain_left[0]  = '0;

  assign load_size = SIZE_BITS'(req_i.part_size);

  for (genvar k = 0; k < NUM_PARTITIONS; k++) begin : g_cell
    bfpa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_en_i   (load_en),
      .load_idx_i  (req_i.part_index),
      .load_size_i (load_size),
      .mark_en_i   (mark_en),
      .mark_idx_i  (chain_idx[NUM_PARTITIONS]),
      .req_size_i  (req_size_q),
      .found_i     (chain_found[k]),
      .idx_i       (chain_idx[k]),
      .left_i      (chain_left[k]),
      .found_o     (chain_found[k+1]),
      .idx_o       (chain_idx[k+1]),
      .left_o      (chain_left[k+1])
    );
  end

  assign sum_ext = {1'b0, sum_q} + 33'(chain_left[NUM_PARTITIONS]);
  assign busy    = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    req_size_d = req_size_q;
    sum_d      = sum_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    load_en    = 1'b0;
    mark_en    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.op == OP_LOAD) begin
            load_en                = 1'b1;
            done_d                 = 1'b1;
            rsp_d.status           = ST_LOADED;
            rsp_d.chosen_partition = '0;
            rsp_d.leftover         = '0;
            rsp_d.total_leftover   = sum_q;
          end else begin
            req_size_d = SIZE_BITS'(req_i.request_size);
            cnt_d      = '0;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_PARTITIONS - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (chain_found[NUM_PARTITIONS]) begin
          mark_en                = 1'b1;
          sum_d                  = sum_ext[32] ? '1 : sum_ext[31:0];
          rsp_d.status           = ST_ALLOCATED;
          rsp_d.chosen_partition = 4'(chain_idx[NUM_PARTITIONS]);
          rsp_d.leftover         = 16'(chain_left[NUM_PARTITIONS]);
          rsp_d.total_leftover   = sum_d;
        end else begin
          rsp_d.status           = ST_NO_FIT;
          rsp_d.chosen_partition = '0;
          rsp_d.leftover         = '0;
          rsp_d.total_leftover   = sum_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_size_q <= req_size_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == OP_ALLOC) |=> busy)
    else $error("allocate request did not raise busy");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == OP_LOAD) |=> (done_o && rsp_o.status == ST_LOADED))
    else $error("load request not answered in the next cycle");

  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q >= $past(sum_q))
    else $error("running leftover total decreased");

  a_no_fit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_NO_FIT) |-> (rsp_o.leftover == '0 && $stable(sum_q)))
    else $error("no-fit result changed leftover state");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the best-fit partition allocator: directed and random runs.
module tb_top;
  import bfpa_pkg::*;

  typedef struct {
    req_t        req;
    int unsigned gap;
  } stim_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  req_t  alloc_req = '0;
  logic  done_o;
  rsp_t  alloc_rsp;

  stim_t req_queue[$];
  rsp_t  alloc_result_queue[$];

  logic [15:0] slot_size [NUM_PARTITIONS_DEF] = '{default: '0};
  logic        slot_used [NUM_PARTITIONS_DEF] = '{default: 1'b0};
  logic [31:0] leftover_total = '0;

  int unsigned hold_cnt = 0;
  logic        gap_taken = 1'b0;
  int unsigned mismatch_cnt = 0;
  logic [15:0] gen_size [NUM_PARTITIONS_DEF] = '{default: '0};
  int unsigned idle_max = 0;

  best_fit_partition_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (alloc_req),
    .done_o (done_o),
    .rsp_o  (alloc_rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rsp_t best_fit_result(req_t r);
    rsp_t        res;
    logic        found;
    logic [3:0]  best;
    logic [15:0] best_left;
    res = '0;
    res.status = ST_LOADED;
    if (r.op == OP_LOAD) begin
      slot_size[r.part_index] = r.part_size;
      slot_used[r.part_index] = 1'b0;
    end else begin
      found = 1'b0;
      best = '0;
      best_left = '0;
      for (int k = 0; k < NUM_PARTITIONS_DEF; k++) begin
        if (!slot_used[k] && slot_size[k] != 16'd0 && slot_size[k] >= r.request_size) begin
          if (!found || (slot_size[k] - r.request_size) < best_left) begin
            found = 1'b1;
            best = k[3:0];
            best_left = slot_size[k] - r.request_size;
          end
        end
      end
      if (found) begin
        slot_used[best] = 1'b1;
        res.status = ST_ALLOCATED;
        res.chosen_partition = best;
        res.leftover = best_left;
        if (leftover_total > (32'hFFFF_FFFF - {16'd0, best_left})) begin
          leftover_total = 32'hFFFF_FFFF;
        end else begin
          leftover_total = leftover_total + {16'd0, best_left};
        end
      end else begin
        res.status = ST_NO_FIT;
      end
    end
    res.total_leftover = leftover_total;
    return res;
  endfunction

  // driver: predict on acceptance, then present the next request after its gap
  always @(posedge clk_i or negedge rst_ni) begin : drive
    stim_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      alloc_req <= '0;
      hold_cnt <= 0;
      gap_taken <= 1'b0;
    end else begin
      if (start && !busy) begin
        alloc_result_queue.push_back(best_fit_result(alloc_req));
      end
      if (!start || !busy) begin
        if (hold_cnt > 0) begin
          start <= 1'b0;
          hold_cnt <= hold_cnt - 1;
        end else if (req_queue.size() > 0) begin
          nxt = req_queue[0];
          if (nxt.gap > 0 && !gap_taken) begin
            start <= 1'b0;
            hold_cnt <= nxt.gap - 1;
            gap_taken <= 1'b1;
          end else begin
            void'(req_queue.pop_front());
            start <= 1'b1;
            alloc_req <= nxt.req;
            gap_taken <= 1'b0;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin : watch
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (alloc_result_queue.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10) begin
          $display("%0t: unexpected result status=%0d chosen=%0d leftover=%0d total=%0d",
                   $realtime, alloc_rsp.status, alloc_rsp.chosen_partition,
                   alloc_rsp.leftover, alloc_rsp.total_leftover);
        end
      end else begin
        exp_rsp = alloc_result_queue.pop_front();
        if (alloc_rsp.status !== exp_rsp.status
            || alloc_rsp.chosen_partition !== exp_rsp.chosen_partition
            || alloc_rsp.leftover !== exp_rsp.leftover
            || alloc_rsp.total_leftover !== exp_rsp.total_leftover) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch exp status=%0d chosen=%0d leftover=%0d total=%0d",
                     $realtime, exp_rsp.status, exp_rsp.chosen_partition,
                     exp_rsp.leftover, exp_rsp.total_leftover);
            $display("%0t:          got status=%0d chosen=%0d leftover=%0d total=%0d",
                     $realtime, alloc_rsp.status, alloc_rsp.chosen_partition,
                     alloc_rsp.leftover, alloc_rsp.total_leftover);
          end
        end
      end
    end
  end

  function automatic int unsigned draw_gap();
    if (idle_max == 0) return 0;
    return $urandom_range(0, idle_max);
  endfunction

  task automatic add_load(input logic [3:0] idx, input logic [15:0] size);
    stim_t s;
    s.req.op = OP_LOAD;
    s.req.part_index = idx;
    s.req.part_size = size;
    s.req.request_size = 16'($urandom);
    s.gap = draw_gap();
    gen_size[idx] = size;
    req_queue.push_back(s);
  endtask

  task automatic add_alloc(input logic [15:0] want);
    stim_t s;
    s.req.op = OP_ALLOC;
    s.req.part_index = 4'($urandom);
    s.req.part_size = 16'($urandom);
    s.req.request_size = want;
    s.gap = draw_gap();
    req_queue.push_back(s);
  endtask

  initial begin : stimulus
    int unsigned sel;
    int unsigned k;
    logic [15:0] want;

    // directed: empty table, unusable slot, ties, zero request, reload of a used slot
    idle_max = 3;
    add_alloc(16'd1);
    add_load(4'd0, 16'd0);
    add_alloc(16'd1);
    add_load(4'd15, 16'hFFFF);
    add_load(4'd3, 16'd100);
    add_load(4'd7, 16'd100);
    add_load(4'd1, 16'd50);
    add_alloc(16'd0);
    add_alloc(16'd100);
    add_alloc(16'd100);
    add_alloc(16'd100);
    add_alloc(16'd1);
    add_load(4'd3, 16'd100);
    add_alloc(16'hFFFF);
    add_alloc(16'd100);
    add_load(4'd10, 16'hFFFF);
    add_alloc(16'hFFFF);
    add_load(4'd0, 16'h5555);
    add_load(4'd5, 16'hAAAA);
    add_alloc(16'h5555);
    add_alloc(16'h0001);
    add_alloc(16'h0000);

    // random: blocks of requests, some blocks with no idling at all
    for (int i = 0; i < 1825; i++) begin
      if (i % 50 == 0) begin
        idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      end
      k = $urandom_range(0, NUM_PARTITIONS_DEF - 1);
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 45) begin
        case (sel)
          0:       want = 16'd0;
          1, 2, 3: want = gen_size[k];
          4, 5:    want = (gen_size[k] > 16'd8) ? 16'(gen_size[k] - $urandom_range(1, 8))
                                                : gen_size[k];
          6, 7:    want = 16'($urandom_range(1, 64));
          8:       want = 16'($urandom);
          default: want = 16'hFFFF;
        endcase
        add_alloc(want);
      end else begin
        case (sel)
          0:          want = 16'd0;
          1, 2, 3, 4: want = 16'($urandom_range(1, 64));
          5, 6, 7:    want = 16'($urandom_range(1, 65535));
          8:          want = 16'hFFFF;
          default:    want = 16'($urandom);
        endcase
        add_load(k[3:0], want);
      end
    end

    idle_max = 4;
    add_load(4'd5, 16'd10);
    add_alloc(16'd3);
    add_alloc(16'd3);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || start || alloc_result_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== best_fit_partition_allocator.f =====
rtl/bfpa_pkg.sv
rtl/bfpa_cell.sv
rtl/best_fit_partition_allocator.sv
tb/tb_top.sv
